// ----- rtl/core/qrfp_pkg.sv -----
// ----------------------------------------------------------------------------
// qrfp_pkg
// Shared types, constants and the alignment center table for the QR
// function-pattern classifier.
// ----------------------------------------------------------------------------
package qrfp_pkg;

   localparam int unsigned MAX_VERSION = 40;
   localparam int unsigned VERSION_W   = 6;
   localparam int unsigned COORD_W     = 8;
   localparam int unsigned ALIGN_MAX   = 7;     // centers per axis, largest version
   localparam int unsigned REQ_DATA_W  = 2 * COORD_W;
   localparam int unsigned RSP_DATA_W  = 8;
   localparam int unsigned RSP_FLAGS_W = 3;

   localparam logic [COORD_W-1:0] SIZE_BASE   = 8'd17;
   localparam logic [COORD_W-1:0] FINDER_CTR  = 8'd3;
   localparam logic [COORD_W-1:0] FINDER_EDGE = 8'd7;
   localparam logic [COORD_W-1:0] TIMING_LINE = 8'd6;
   localparam logic [COORD_W-1:0] TIMING_LO   = 8'd8;
   localparam logic [COORD_W-1:0] ALIGN_KEEP  = 8'd10;

   // result flags, is_function in bit 0
   typedef struct packed {
      logic outside;
      logic dark;
      logic is_function;
   } qrfp_result_type;

   // alignment centers for one version, entry i at bits [8i+7:8i];
   // unused entries are zero (zero is never a real center)
   function automatic logic [ALIGN_MAX*COORD_W-1:0] align_row(
      input logic [VERSION_W-1:0] version
   );
      logic [ALIGN_MAX*COORD_W-1:0] r;
      unique case (version)
         6'd2:    r = {8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd18, 8'd6};
         6'd3:    r = {8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd22, 8'd6};
         6'd4:    r = {8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd26, 8'd6};
         6'd5:    r = {8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd30, 8'd6};
         6'd6:    r = {8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd34, 8'd6};
         6'd7:    r = {8'd0, 8'd0, 8'd0, 8'd0, 8'd38, 8'd22, 8'd6};
         6'd8:    r = {8'd0, 8'd0, 8'd0, 8'd0, 8'd42, 8'd24, 8'd6};
         6'd9:    r = {8'd0, 8'd0, 8'd0, 8'd0, 8'd46, 8'd26, 8'd6};
         6'd10:   r = {8'd0, 8'd0, 8'd0, 8'd0, 8'd50, 8'd28, 8'd6};
         6'd11:   r = {8'd0, 8'd0, 8'd0, 8'd0, 8'd54, 8'd30, 8'd6};
         6'd12:   r = {8'd0, 8'd0, 8'd0, 8'd0, 8'd58, 8'd32, 8'd6};
         6'd13:   r = {8'd0, 8'd0, 8'd0, 8'd0, 8'd62, 8'd34, 8'd6};
         6'd14:   r = {8'd0, 8'd0, 8'd0, 8'd66, 8'd46, 8'd26, 8'd6};
         6'd15:   r = {8'd0, 8'd0, 8'd0, 8'd70, 8'd48, 8'd26, 8'd6};
         6'd16:   r = {8'd0, 8'd0, 8'd0, 8'd74, 8'd50, 8'd26, 8'd6};
         6'd17:   r = {8'd0, 8'd0, 8'd0, 8'd78, 8'd54, 8'd30, 8'd6};
         6'd18:   r = {8'd0, 8'd0, 8'd0, 8'd82, 8'd56, 8'd30, 8'd6};
         6'd19:   r = {8'd0, 8'd0, 8'd0, 8'd86, 8'd58, 8'd30, 8'd6};
         6'd20:   r = {8'd0, 8'd0, 8'd0, 8'd90, 8'd62, 8'd34, 8'd6};
         6'd21:   r = {8'd0, 8'd0, 8'd94, 8'd72, 8'd50, 8'd28, 8'd6};
         6'd22:   r = {8'd0, 8'd0, 8'd98, 8'd74, 8'd50, 8'd26, 8'd6};
         6'd23:   r = {8'd0, 8'd0, 8'd102, 8'd78, 8'd54, 8'd30, 8'd6};
         6'd24:   r = {8'd0, 8'd0, 8'd106, 8'd80, 8'd54, 8'd28, 8'd6};
         6'd25:   r = {8'd0, 8'd0, 8'd110, 8'd84, 8'd58, 8'd32, 8'd6};
         6'd26:   r = {8'd0, 8'd0, 8'd114, 8'd86, 8'd58, 8'd30, 8'd6};
         6'd27:   r = {8'd0, 8'd0, 8'd118, 8'd90, 8'd62, 8'd34, 8'd6};
         6'd28:   r = {8'd0, 8'd122, 8'd98, 8'd74, 8'd50, 8'd26, 8'd6};
         6'd29:   r = {8'd0, 8'd126, 8'd102, 8'd78, 8'd54, 8'd30, 8'd6};
         6'd30:   r = {8'd0, 8'd130, 8'd104, 8'd78, 8'd52, 8'd26, 8'd6};
         6'd31:   r = {8'd0, 8'd134, 8'd108, 8'd82, 8'd56, 8'd30, 8'd6};
         6'd32:   r = {8'd0, 8'd138, 8'd112, 8'd86, 8'd60, 8'd34, 8'd6};
         6'd33:   r = {8'd0, 8'd142, 8'd114, 8'd86, 8'd58, 8'd30, 8'd6};
         6'd34:   r = {8'd0, 8'd146, 8'd118, 8'd90, 8'd62, 8'd34, 8'd6};
         6'd35:   r = {8'd150, 8'd126, 8'd102, 8'd78, 8'd54, 8'd30, 8'd6};
         6'd36:   r = {8'd154, 8'd128, 8'd102, 8'd76, 8'd50, 8'd24, 8'd6};
         6'd37:   r = {8'd158, 8'd132, 8'd106, 8'd80, 8'd54, 8'd28, 8'd6};
         6'd38:   r = {8'd162, 8'd136, 8'd110, 8'd84, 8'd58, 8'd32, 8'd6};
         6'd39:   r = {8'd166, 8'd138, 8'd110, 8'd82, 8'd54, 8'd26, 8'd6};
         6'd40:   r = {8'd170, 8'd142, 8'd114, 8'd86, 8'd58, 8'd30, 8'd6};
         default: r = '0;    // version 1 has no alignment pattern
      endcase
      return r;
   endfunction

endpackage

// ----- rtl/core/qr_function_pattern_classifier.sv -----
// ----------------------------------------------------------------------------
// qr_function_pattern_classifier
// Streams module coordinates in and tells, per coordinate, whether it is a
// function-pattern module of the configured QR version and its color.
// ----------------------------------------------------------------------------
// One beat in, one beat out. The block takes a coordinate every cycle
// unless back-pressure holds it off. The coordinate is captured in an
// input register, classified by one pass of combinational logic (finder
// and separator corners, alignment centers from a per-version table,
// timing lines, dark module) and held in the result register until the
// sink takes it. Back-pressure stalls the pipe one stage at a time, so a
// full output register does not block a new input while stage one is
// empty. Version writes (0 reads as 1, above 40 as 40) must only happen
// with the pipe empty. Format and version info areas are reported as
// ordinary data modules.
module qr_function_pattern_classifier (
   input  logic                              clock,
   input  logic                              reset,
   // input coordinates
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [qrfp_pkg::REQ_DATA_W-1:0]   req_tdata,   // [7:0] column, [15:8] row
   // classification results
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [qrfp_pkg::RSP_DATA_W-1:0]   rsp_tdata,   // [0] is_function, [1] dark,
                                                         // [2] outside, [7:3] zero
   // version register
   input  logic                              csr_wen,
   input  logic [qrfp_pkg::VERSION_W-1:0]    csr_wdata
);
   import qrfp_pkg::*;

   logic [VERSION_W-1:0] version_ff;
   logic [VERSION_W-1:0] version_in;

   // stage 1: captured coordinate
   logic                 s1_valid_ff;
   logic                 s1_valid_in;
   logic [COORD_W-1:0]   column_ff;
   logic [COORD_W-1:0]   row_ff;

   // stage 2: result register
   logic                 rsp_valid_ff;
   logic                 rsp_valid_in;
   qrfp_result_type      result_ff;
   qrfp_result_type      result_comb;

   logic                 s2_ready;
   logic                 req_beat;

   // clamp at write so the datapath sees 1..40 only
   always_comb begin
      version_in = version_ff;
      if (csr_wen) begin
         if (csr_wdata == '0) begin
            version_in = VERSION_W'(1);
         end else if (csr_wdata > VERSION_W'(MAX_VERSION)) begin
            version_in = VERSION_W'(MAX_VERSION);
         end else begin
            version_in = csr_wdata;
         end
      end
   end

   // handshake: each stage moves when the next one is free or draining
   assign s2_ready   = !rsp_valid_ff || rsp_tready;
   assign req_tready = !s1_valid_ff || s2_ready;
   assign req_beat   = req_tvalid && req_tready;

   assign s1_valid_in  = req_beat || (s1_valid_ff && !s2_ready);
   assign rsp_valid_in = s2_ready ? s1_valid_ff : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         version_ff   <= VERSION_W'(1);
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         version_ff   <= version_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      if (req_beat) begin
         column_ff <= req_tdata[COORD_W-1:0];
         row_ff    <= req_tdata[REQ_DATA_W-1:COORD_W];
      end
      if (s2_ready && s1_valid_ff) begin
         result_ff <= result_comb;
      end
   end

   qrfp_classify u_classify (
      .version (version_ff),
      .column  (column_ff),
      .row     (row_ff),
      .result  (result_comb)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W-RSP_FLAGS_W){1'b0}}, result_ff};

   // ---- checks ----
   a_dark_is_function: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && result_ff.dark |-> result_ff.is_function)
      else $error("dark set on a non-function module");

   a_outside_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && result_ff.outside |-> !result_ff.is_function && !result_ff.dark)
      else $error("outside coordinate classified as function module");

   a_version_range: assert property (@(posedge clock) disable iff (reset)
      version_ff >= VERSION_W'(1) && version_ff <= VERSION_W'(MAX_VERSION))
      else $error("version register out of range");

   a_stage_advance: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && s2_ready |=> rsp_valid_ff)
      else $error("stage one beat lost on advance");

   a_zero_version: assert property (@(posedge clock) disable iff (reset)
      csr_wen && csr_wdata == '0 |=> version_ff == VERSION_W'(1))
      else $error("version zero not mapped to one");

endmodule

// ----- rtl/core/qrfp_classify.sv -----
// ----------------------------------------------------------------------------
// qrfp_classify
// Combinational classification of one module coordinate against the
// finder, separator, alignment, timing and dark-module areas.
// ----------------------------------------------------------------------------
module qrfp_classify (
   input  logic [qrfp_pkg::VERSION_W-1:0] version,   // already clamped to 1..40
   input  logic [qrfp_pkg::COORD_W-1:0]   column,
   input  logic [qrfp_pkg::COORD_W-1:0]   row,
   output qrfp_pkg::qrfp_result_type      result
);
   import qrfp_pkg::*;

   typedef struct packed {
      logic               hit;
      logic [COORD_W-1:0] ctr;
      logic [1:0]         offs;
   } qrfp_axis_type;

   function automatic logic [COORD_W-1:0] abs_diff(
      input logic [COORD_W-1:0] a,
      input logic [COORD_W-1:0] b
   );
      return (a >= b) ? a - b : b - a;
   endfunction

   // centers are at least 12 apart, so at most one is within 2 of pos
   function automatic qrfp_axis_type axis_match(
      input logic [COORD_W-1:0]           pos,
      input logic [ALIGN_MAX*COORD_W-1:0] centers
   );
      qrfp_axis_type      m;
      logic [COORD_W-1:0] c;
      logic [COORD_W-1:0] diff;
      m = '0;
      for (int i = 0; i < ALIGN_MAX; i++) begin
         c    = centers[i*COORD_W +: COORD_W];
         diff = abs_diff(pos, c);
         if (c != '0 && diff <= 8'd2) begin
            m.hit  = 1'b1;
            m.ctr  = c;
            m.offs = diff[1:0];
         end
      end
      return m;
   endfunction

   logic [COORD_W-1:0]           size;
   logic [ALIGN_MAX*COORD_W-1:0] centers;
   qrfp_axis_type                mx;
   qrfp_axis_type                my;
   logic                         in_finder;
   logic [COORD_W-1:0]           fcx;
   logic [COORD_W-1:0]           fcy;
   logic [COORD_W-1:0]           fdx;
   logic [COORD_W-1:0]           fdy;
   logic [COORD_W-1:0]           fd;
   logic                         align_skip;
   logic [1:0]                   ad;
   logic                         isf;
   logic                         dk;

   assign size    = {version, 2'b00} + SIZE_BASE;
   assign centers = align_row(version);
   assign mx      = axis_match(column, centers);
   assign my      = axis_match(row, centers);

   always_comb begin
      in_finder = 1'b1;
      fcx       = FINDER_CTR;
      fcy       = FINDER_CTR;
      if (column <= FINDER_EDGE && row <= FINDER_EDGE) begin
         fcx = FINDER_CTR;
      end else if (column >= size - 8'd8 && row <= FINDER_EDGE) begin
         fcx = size - 8'd4;
      end else if (column <= FINDER_EDGE && row >= size - 8'd8) begin
         fcy = size - 8'd4;
      end else begin
         in_finder = 1'b0;
      end
   end

   assign fdx = abs_diff(column, fcx);
   assign fdy = abs_diff(row, fcy);
   assign fd  = (fdx > fdy) ? fdx : fdy;

   // no alignment pattern overlapping a finder corner
   assign align_skip = (mx.ctr < ALIGN_KEEP && my.ctr < ALIGN_KEEP) ||
                       (mx.ctr > size - ALIGN_KEEP && my.ctr < ALIGN_KEEP) ||
                       (mx.ctr < ALIGN_KEEP && my.ctr > size - ALIGN_KEEP);
   assign ad = (mx.offs > my.offs) ? mx.offs : my.offs;

   // later checks override earlier ones
   always_comb begin
      isf = 1'b0;
      dk  = 1'b0;
      if (in_finder) begin
         isf = 1'b1;
         dk  = (fd < 8'd4) && (fd != 8'd2);
      end
      if (mx.hit && my.hit && !align_skip) begin
         isf = 1'b1;
         dk  = (ad != 2'd1);
      end
      if (row == TIMING_LINE && column >= TIMING_LO && column <= size - 8'd9) begin
         isf = 1'b1;
         dk  = ~column[0];
      end
      if (column == TIMING_LINE && row >= TIMING_LO && row <= size - 8'd9) begin
         isf = 1'b1;
         dk  = ~row[0];
      end
      if (column == TIMING_LO && row == size - 8'd8) begin
         isf = 1'b1;
         dk  = 1'b1;
      end
   end

   always_comb begin
      result = '0;
      if (column >= size || row >= size) begin
         result.outside = 1'b1;
      end else begin
         result.is_function = isf;
         result.dark        = isf & dk;
      end
   end

endmodule

// ----- tb/qr_function_pattern_classifier_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qr_function_pattern_classifier_tb
// Self-checking bench for the QR function-pattern classifier. A short table
// of hand-picked coordinates (finder corners, rings, separators, timing
// lines, dark module, alignment centers, off-symbol points, version zero and
// versions above 40) runs first. Random phases follow, one version per
// phase, with coordinates biased toward the pattern areas. Every beat out is
// compared with a table row or a local classifier; both ends idle randomly.
// ----------------------------------------------------------------------------
module qr_function_pattern_classifier_tb;

   import qrfp_pkg::*;

   localparam int unsigned PHASES         = 12;
   localparam int unsigned PHASE_BEATS    = 100;
   localparam int unsigned MAX_GAP        = 18;
   localparam int unsigned WATCHDOG_LIMIT = 1000;   // cycles with no beat on either side
   localparam int unsigned DIR_ROWS       = 25;

   // classification codes: {outside, dark, is_function}
   localparam qrfp_result_type FN_DARK  = 3'b011;
   localparam qrfp_result_type FN_LIGHT = 3'b001;
   localparam qrfp_result_type DATA_MOD = 3'b000;
   localparam qrfp_result_type OFF_SYM  = 3'b100;

   // one directed coordinate; want is only used when typed is set
   typedef struct packed {
      logic [VERSION_W-1:0] ver;
      logic [COORD_W-1:0]   col;
      logic [COORD_W-1:0]   row;
      logic                 typed;
      qrfp_result_type      want;
   } dir_row_type;

   dir_row_type dir_plan [DIR_ROWS] = '{
      // version 1, size 21
      '{6'd1,  8'd0,   8'd0,   1'b1, FN_DARK},    // finder outer ring
      '{6'd1,  8'd3,   8'd3,   1'b1, FN_DARK},    // finder core
      '{6'd1,  8'd1,   8'd1,   1'b1, FN_LIGHT},   // finder light ring
      '{6'd1,  8'd7,   8'd7,   1'b1, FN_LIGHT},   // separator corner
      '{6'd1,  8'd8,   8'd6,   1'b1, FN_DARK},    // timing row, even
      '{6'd1,  8'd9,   8'd6,   1'b1, FN_LIGHT},   // timing row, odd
      '{6'd1,  8'd6,   8'd12,  1'b1, FN_DARK},    // timing column, last module
      '{6'd1,  8'd8,   8'd13,  1'b1, FN_DARK},    // dark module
      '{6'd1,  8'd20,  8'd0,   1'b1, FN_DARK},    // top-right finder corner
      '{6'd1,  8'd0,   8'd20,  1'b1, FN_DARK},    // bottom-left finder corner
      '{6'd1,  8'd20,  8'd20,  1'b1, DATA_MOD},   // bottom-right, no finder
      '{6'd1,  8'd10,  8'd10,  1'b1, DATA_MOD},
      '{6'd1,  8'd21,  8'd0,   1'b1, OFF_SYM},    // first column past the edge
      '{6'd1,  8'd255, 8'd255, 1'b1, OFF_SYM},
      // version zero reads as version 1
      '{6'd0,  8'd8,   8'd13,  1'b1, FN_DARK},
      '{6'd0,  8'd0,   8'd21,  1'b1, OFF_SYM},
      // version 2, single alignment pattern at (18,18)
      '{6'd2,  8'd18,  8'd18,  1'b1, FN_DARK},
      '{6'd2,  8'd17,  8'd17,  1'b1, FN_LIGHT},
      // all ones saturates to 40, size 177
      '{6'd63, 8'd176, 8'd176, 1'b0, DATA_MOD},
      '{6'd63, 8'd170, 8'd170, 1'b1, FN_DARK},
      '{6'd63, 8'd177, 8'd0,   1'b1, OFF_SYM},
      '{6'd63, 8'd30,  8'd6,   1'b0, DATA_MOD},   // timing over alignment
      '{6'd40, 8'd31,  8'd6,   1'b0, DATA_MOD},
      '{6'd40, 8'd170, 8'd171, 1'b0, DATA_MOD},
      '{6'd7,  8'd22,  8'd6,   1'b0, DATA_MOD}
   };

   logic                    clock;
   logic                    reset      = 1'b1;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [REQ_DATA_W-1:0]   req_tdata  = '0;      // [7:0] column, [15:8] row
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]   rsp_tdata;            // [0] is_function, [1] dark,
                                                  // [2] outside, [7:3] zero
   logic                    csr_wen    = 1'b0;
   logic [VERSION_W-1:0]    csr_wdata  = '0;

   // expected classification per accepted coordinate, oldest first
   qrfp_result_type         pending_class [$];
   logic [VERSION_W-1:0]    version_mirror = 6'd1;   // register value after reset
   bit                      req_burst = 1'b0;
   bit                      rsp_burst = 1'b0;
   int unsigned             mismatches  = 0;
   int unsigned             coords_sent = 0;
   int unsigned             n_function  = 0;
   int unsigned             n_dark      = 0;
   int unsigned             n_outside   = 0;
   int unsigned             n_writes    = 0;

   qr_function_pattern_classifier dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wen    (csr_wen),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // Classifier
   // ---------------------------------------------------------------------

   // version 0 behaves as 1, anything above the table as the largest
   function automatic int unsigned eff_version(input logic [VERSION_W-1:0] v);
      if (v == 0)
         return 1;
      if (v > MAX_VERSION)
         return MAX_VERSION;
      return 32'(v);
   endfunction

   // Alignment center i of version v (v >= 2): first at 6, last at size-7,
   // the rest evenly spaced back from the last; version 32 is the one
   // irregular spacing in the standard.
   function automatic int unsigned align_center(input int unsigned v, input int unsigned i);
      int unsigned cnt, step;
      cnt  = v / 7 + 2;
      step = (v == 32) ? 26 : ((v * 4 + cnt * 2 + 1) / (cnt * 2 - 2)) * 2;
      if (i == 0)
         return 6;
      return 4 * v + 17 - 7 - (cnt - 1 - i) * step;
   endfunction

   // Chebyshev distance: squares around a center are its rings
   function automatic int cheb(input int x, input int y, input int cx, input int cy);
      int dx, dy;
      dx = (x > cx) ? x - cx : cx - x;
      dy = (y > cy) ? y - cy : cy - y;
      return (dx > dy) ? dx : dy;
   endfunction

   function automatic qrfp_result_type classify_module(
      input logic [VERSION_W-1:0] ver_reg,
      input logic [COORD_W-1:0]   col,
      input logic [COORD_W-1:0]   row
   );
      int              v, sz, cnt, x, y, cx, cy, d;
      logic            fn, dk;
      qrfp_result_type r;
      v  = eff_version(ver_reg);
      sz = 4 * v + 17;
      x  = int'(col);
      y  = int'(row);
      r  = DATA_MOD;
      fn = 1'b0;
      dk = 1'b0;
      if (x >= sz || y >= sz) begin
         r.outside = 1'b1;
         return r;
      end
      // finder 7x7 plus separator: rings 0,1,3 dark, ring 2 and 4 light
      if (x <= 7 && y <= 7) begin
         d  = cheb(x, y, 3, 3);
         fn = 1'b1;
         dk = (d < 4) && (d != 2);
      end else if (x >= sz - 8 && y <= 7) begin
         d  = cheb(x, y, sz - 4, 3);
         fn = 1'b1;
         dk = (d < 4) && (d != 2);
      end else if (x <= 7 && y >= sz - 8) begin
         d  = cheb(x, y, 3, sz - 4);
         fn = 1'b1;
         dk = (d < 4) && (d != 2);
      end
      // alignment grid, three finder corners left out
      cnt = (v >= 2) ? v / 7 + 2 : 0;
      for (int i = 0; i < cnt; i++) begin
         for (int j = 0; j < cnt; j++) begin
            cx = align_center(v, i);
            cy = align_center(v, j);
            if (!((cx < 10 && cy < 10) || (cx > sz - 10 && cy < 10) ||
                  (cx < 10 && cy > sz - 10))) begin
               d = cheb(x, y, cx, cy);
               if (d <= 2) begin
                  fn = 1'b1;
                  dk = (d != 1);
               end
            end
         end
      end
      // timing lines override alignment, dark module overrides all
      if (y == 6 && x >= 8 && x <= sz - 9) begin
         fn = 1'b1;
         dk = (x % 2 == 0);
      end
      if (x == 6 && y >= 8 && y <= sz - 9) begin
         fn = 1'b1;
         dk = (y % 2 == 0);
      end
      if (x == 8 && y == sz - 8) begin
         fn = 1'b1;
         dk = 1'b1;
      end
      r.is_function = fn;
      r.dark        = fn & dk;
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------

   // one coordinate beat; valid stays high when the next beat has no gap
   task automatic send_coord(
      input logic [COORD_W-1:0] col,
      input logic [COORD_W-1:0] row,
      input logic               typed,
      input qrfp_result_type    want
   );
      int unsigned gap;
      gap = req_burst ? 0 : $urandom_range(0, MAX_GAP);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {row, col};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pending_class.push_back(typed ? want : classify_module(version_mirror, col, row));
      coords_sent++;
   endtask

   // hold off the sender until every expected beat has come back
   task automatic drain_pipe();
      req_tvalid <= 1'b0;
      while (pending_class.size() != 0) @(posedge clock);
   endtask

   // version writes only with the pipe empty
   task automatic set_version(input logic [VERSION_W-1:0] v);
      drain_pipe();
      csr_wen   <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      csr_wen   <= 1'b0;
      version_mirror = v;
      n_writes++;
   endtask

   // Random coordinate, weighted toward the areas that hold patterns:
   // anywhere in the symbol, the finder bands, around an alignment center,
   // on a timing line, around the dark module, or anywhere in the field.
   task automatic pick_coord(
      input  int unsigned        v,
      output logic [COORD_W-1:0] col,
      output logic [COORD_W-1:0] row
   );
      int unsigned sz, sel;
      sz  = 4 * v + 17;
      sel = $urandom_range(0, 9);
      if ((sel == 5 || sel == 6) && v < 2)
         sel = 0;
      case (sel)
         3, 4: begin
            col = COORD_W'($urandom_range(0, 1) ? $urandom_range(0, 9)
                                                : $urandom_range(sz - 10, sz));
            row = COORD_W'($urandom_range(0, 1) ? $urandom_range(0, 9)
                                                : $urandom_range(sz - 10, sz));
         end
         5, 6: begin
            col = COORD_W'(align_center(v, $urandom_range(0, v / 7 + 1)) +
                           $urandom_range(0, 6) - 3);
            row = COORD_W'(align_center(v, $urandom_range(0, v / 7 + 1)) +
                           $urandom_range(0, 6) - 3);
         end
         7: begin
            if ($urandom_range(0, 1)) begin
               col = COORD_W'($urandom_range(0, sz));
               row = TIMING_LINE;
            end else begin
               col = TIMING_LINE;
               row = COORD_W'($urandom_range(0, sz));
            end
         end
         8: begin
            col = COORD_W'($urandom_range(7, 9));
            row = COORD_W'(sz - 9 + $urandom_range(0, 2));
         end
         9: begin
            col = COORD_W'($urandom_range(0, 255));
            row = COORD_W'($urandom_range(0, 255));
         end
         default: begin
            col = COORD_W'($urandom_range(0, sz - 1));
            row = COORD_W'($urandom_range(0, sz - 1));
         end
      endcase
   endtask

   // ---------------------------------------------------------------------
   // Result side
   // ---------------------------------------------------------------------

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
      mismatches++;
   endtask

   // sink: per beat a random stall, none while rsp_burst is set
   initial begin : rsp_sink
      int unsigned stall;
      forever begin
         stall = rsp_burst ? 0 : $urandom_range(0, MAX_GAP);
         if (stall != 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
      end
   end

   always @(posedge clock) begin : rsp_check
      qrfp_result_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata[RSP_FLAGS_W-1:0];
         if (pending_class.size() == 0) begin
            report_mismatch("beat with nothing pending", int'(got), 0);
         end else begin
            want = pending_class.pop_front();
            if (got.is_function !== want.is_function)
               report_mismatch("is_function", int'(got.is_function),
                               int'(want.is_function));
            if (got.dark !== want.dark)
               report_mismatch("dark", int'(got.dark), int'(want.dark));
            if (got.outside !== want.outside)
               report_mismatch("outside", int'(got.outside), int'(want.outside));
            if (rsp_tdata[RSP_DATA_W-1:RSP_FLAGS_W] !== '0)
               report_mismatch("tdata pad", int'(rsp_tdata[RSP_DATA_W-1:RSP_FLAGS_W]), 0);
         end
         n_function += 32'(got.is_function);
         n_dark     += 32'(got.dark);
         n_outside  += 32'(got.outside);
      end
   end

   // watchdog: a stuck handshake on either side ends the run
   initial begin : watchdog
      int unsigned idle;
      idle = 0;
      while (idle < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            idle = 0;
         else
            idle++;
      end
      $display("watchdog: %0d cycles without a beat, %0d results pending",
               WATCHDOG_LIMIT, pending_class.size());
      $display("status: fail");
      $finish;
   end

   // ---------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------
   initial begin : main_seq
      logic [VERSION_W-1:0] ver;
      logic [COORD_W-1:0]   col, row;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table, version changes only between drained beats
      foreach (dir_plan[k]) begin
         if (dir_plan[k].ver != version_mirror)
            set_version(dir_plan[k].ver);
         send_coord(dir_plan[k].col, dir_plan[k].row, dir_plan[k].typed, dir_plan[k].want);
      end

      // random phases: extremes first, then any 6-bit value
      for (int p = 0; p < PHASES; p++) begin
         case (p)
            0:       ver = VERSION_W'(MAX_VERSION);
            1:       ver = 6'd0;
            2:       ver = 6'd63;
            3:       ver = 6'd1;
            default: ver = VERSION_W'(($urandom_range(0, 4) == 0) ? $urandom_range(0, 63)
                                                     : $urandom_range(1, MAX_VERSION));
         endcase
         set_version(ver);
         req_burst = ($urandom_range(0, 2) == 0);
         rsp_burst = ($urandom_range(0, 2) == 0);
         for (int b = 0; b < PHASE_BEATS; b++) begin
            pick_coord(eff_version(ver), col, row);
            send_coord(col, row, 1'b0, DATA_MOD);
         end
      end

      drain_pipe();
      repeat (8) @(posedge clock);

      $display("covered %0d coordinates over %0d version writes, directed rows and %0d phases",
               coords_sent, n_writes, PHASES);
      $display("seen %0d function modules (%0d dark), %0d off-symbol, %0d mismatches",
               n_function, n_dark, n_outside, mismatches);
      if (mismatches == 0 && pending_class.size() == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

// ----- sim.f -----
rtl/core/qrfp_pkg.sv
rtl/core/qrfp_classify.sv
rtl/core/qr_function_pattern_classifier.sv
tb/qr_function_pattern_classifier_tb.sv
